// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ftmg_pkg.sv
// Package for the frame-time mode governor: state type, event codes,
// register map and fixed-point constants. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ftmg_pkg;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_FT,
        S_CPU,
        S_GAIN,
        S_ENT,
        S_REL,
        S_MUL_FT,
        S_UPD_FT,
        S_MUL_CPU,
        S_UPD_CPU,
        S_MUL_VAR,
        S_UPD_VAR,
        S_DECIDE
    } state_t;

    // Mode switch events.
    localparam logic [1:0] MEV_NONE    = 2'd0;
    localparam logic [1:0] MEV_TO_PERF = 2'd1;
    localparam logic [1:0] MEV_TO_QUAL = 2'd2;

    // Predictive mode events.
    localparam logic [1:0] PEV_NONE     = 2'd0;
    localparam logic [1:0] PEV_APPROACH = 2'd1;
    localparam logic [1:0] PEV_CRUISE   = 2'd2;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_FPS_TARGET     = 3'd0;
    localparam logic [2:0] REG_FPS_MARGIN     = 3'd1;
    localparam logic [2:0] REG_CPU_THRESHOLD  = 3'd2;
    localparam logic [2:0] REG_CPU_MARGIN     = 3'd3;
    localparam logic [2:0] REG_SWITCH_HOLDOFF = 3'd4;
    localparam logic [2:0] REG_PRED_HOLDOFF   = 3'd5;
    localparam logic [2:0] REG_PRED_RELEASE   = 3'd6;
    localparam logic [2:0] REG_MEAS_NOISE     = 3'd7;

    // Register reset values.
    localparam logic [7:0]  RST_FPS_TARGET     = 8'd55;
    localparam logic [5:0]  RST_FPS_MARGIN     = 6'd5;
    localparam logic [15:0] RST_CPU_THRESHOLD  = 16'd4608;
    localparam logic [15:0] RST_CPU_MARGIN     = 16'd512;
    localparam logic [7:0]  RST_SWITCH_HOLDOFF = 8'd10;
    localparam logic [7:0]  RST_PRED_HOLDOFF   = 8'd5;
    localparam logic [7:0]  RST_PRED_RELEASE   = 8'd10;
    localparam logic [15:0] RST_MEAS_NOISE     = 16'd3277;

    // Filter state reset values, and the constant that the gain divisor adds to the predicted variance.
    localparam logic [15:0] RST_ESTIMATE = 16'd4096;
    localparam logic [15:0] RST_VARIANCE = 16'd6554;
    localparam logic [16:0] VAR_FLOOR    = 17'd6554;

    // Divider setup. Each dividend is left-aligned in the 32-bit shift register
    // so that the quotient lands in the low bits after the given step count.
    localparam int DQ_W        = 32;
    localparam int TIME_STEPS  = 24;
    localparam int GAIN_STEPS  = 32;
    localparam int THR_STEPS   = 18;
    localparam logic [31:0] TIME_SCALE   = 32'd16384000;
    localparam logic [31:0] THRESH_SCALE = 32'd256000;
    localparam logic [31:0] TIME_DIVIDEND_AL   = TIME_SCALE << (DQ_W - TIME_STEPS);
    localparam logic [31:0] THRESH_DIVIDEND_AL = THRESH_SCALE << (DQ_W - THR_STEPS);
    localparam logic [5:0]  TIME_CNT = 6'(TIME_STEPS);
    localparam logic [5:0]  GAIN_CNT = 6'(GAIN_STEPS);
    localparam logic [5:0]  THR_CNT  = 6'(THR_STEPS);

    // Clamp a 32-bit quotient to 16 bits.
    function automatic logic [15:0] sat16(input logic [31:0] v);
        logic [15:0] r;
        r = (v[31:16] != 16'd0) ? 16'hFFFF : v[15:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/frametime_mode_governor.sv
// Frame-time mode governor top level: sequencer, shared divider and multiplier,
// register file and decision logic. Depends on ftmg_pkg and assert_macros.svh.
//
// Usage: one sample beat per second enters on the s_ channel. s_tdata carries,
// from bit 0 up, frame_rate[15:0], main_thread_rate[31:16], near_hotspot[32],
// deep_in_hotspot[33], zero padding to 40 bits. Each accepted beat yields
// exactly one result beat on the m_ channel: smooth_frame_time[15:0],
// smooth_cpu_time[31:16], performance_mode[32], predictive_mode[33],
// mode_event[35:34], predict_event[37:36], zero padding to 40 bits.
// The work runs through one restoring divider, one quotient bit a cycle: the
// two rate-to-time conversions, then the Kalman gain, then the two frame
// thresholds. Multiply and update steps on the shared 17x16 multiplier for
// the frame estimate, the CPU estimate and the variance, then a decision
// step, follow. s_tready is high only while the sequencer is idle, so a new
// sample is taken only once the last result has reached the output register.
// The result sits in an output register: a new sample may be accepted while
// it waits. If the receiver still stalls when the next result is ready, the
// sequencer holds in its decision cycle until the output register frees up.
// Reset (aresetn low, synchronous) restores register defaults, the filter
// state, both modes and the seconds counter, and drops m_tvalid.
// Configuration is an APB port with read-back; registers sit at byte address 4*index
// and are meant to be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module frametime_mode_governor (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input sample: frame_rate, main_thread_rate, near_hotspot, deep_in_hotspot.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,
    // Result: smooth_frame_time, smooth_cpu_time, performance_mode,
    // predictive_mode, mode_event, predict_event.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    ftmg_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic [7:0]  fps_target_reg;
    logic [5:0]  fps_margin_reg;
    logic [15:0] cpu_thr_reg;
    logic [15:0] cpu_margin_reg;
    logic [7:0]  switch_hold_reg;
    logic [7:0]  pred_hold_reg;
    logic [7:0]  pred_rel_reg;
    logic [15:0] noise_reg;

    // Filter and mode state.
    logic [15:0] frame_est_reg;
    logic [15:0] cpu_est_reg;
    logic [15:0] var_reg;
    logic        perf_reg;
    logic        pred_reg;
    logic [7:0]  sec_reg;

    // Per-sample working registers.
    logic [15:0] main_rate_reg;
    logic        near_reg;
    logic        deep_reg;
    logic [15:0] p_reg;
    logic [15:0] ft_meas_reg;
    logic [15:0] cpu_meas_reg;
    logic [15:0] k_reg;
    logic [15:0] entry_reg;
    logic [15:0] release_reg;

    // Shared divider.
    logic [16:0] rem_reg;
    logic [16:0] div_reg;
    logic [31:0] dq_reg;
    logic [5:0]  cnt_reg;

    // Shared multiplier output.
    logic [31:0] prod_reg;
    logic        ge_reg;

    // Output register.
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    logic        accept;
    logic        cfg_write;
    logic        out_free;
    logic        div_active;
    logic        div_last;
    logic        div_load;
    logic [31:0] div_dq_init;
    logic [16:0] div_divisor;
    logic [5:0]  div_cnt_init;
    logic [17:0] div_shifted;
    logic [18:0] div_diff;
    logic        div_bit;
    logic [16:0] div_rem_next;
    logic [31:0] div_q_next;
    logic [16:0] mul_a;
    logic [15:0] mul_b;
    logic [32:0] mul_p;
    logic        mul_ge;
    logic [15:0] upd_x;
    logic [16:0] upd_sum;
    logic [15:0] upd_next;
    logic [15:0] p_sat;
    logic [16:0] p_sum;
    logic [7:0]  sec_inc;
    logic [8:0]  fps_rel_sum;
    logic [15:0] cpu_rel_thr;
    logic        deep_eff;
    logic        pred_next;
    logic [1:0]  pev_next;
    logic        perf_next;
    logic [1:0]  mev_next;
    logic        sec_clear;
    logic        bottleneck;

    assign accept    = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign pready    = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign div_active = (state_reg == ftmg_pkg::S_FT) || (state_reg == ftmg_pkg::S_CPU) ||
                        (state_reg == ftmg_pkg::S_GAIN) || (state_reg == ftmg_pkg::S_ENT) ||
                        (state_reg == ftmg_pkg::S_REL);
    assign div_last   = (cnt_reg == 6'd1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ftmg_pkg::S_IDLE:    if (s_tvalid) state_next = ftmg_pkg::S_FT;
            ftmg_pkg::S_FT:      if (div_last) state_next = ftmg_pkg::S_CPU;
            ftmg_pkg::S_CPU:     if (div_last) state_next = ftmg_pkg::S_GAIN;
            ftmg_pkg::S_GAIN:    if (div_last) state_next = ftmg_pkg::S_ENT;
            ftmg_pkg::S_ENT:     if (div_last) state_next = ftmg_pkg::S_REL;
            ftmg_pkg::S_REL:     if (div_last) state_next = ftmg_pkg::S_MUL_FT;
            ftmg_pkg::S_MUL_FT:  state_next = ftmg_pkg::S_UPD_FT;
            ftmg_pkg::S_UPD_FT:  state_next = ftmg_pkg::S_MUL_CPU;
            ftmg_pkg::S_MUL_CPU: state_next = ftmg_pkg::S_UPD_CPU;
            ftmg_pkg::S_UPD_CPU: state_next = ftmg_pkg::S_MUL_VAR;
            ftmg_pkg::S_MUL_VAR: state_next = ftmg_pkg::S_UPD_VAR;
            ftmg_pkg::S_UPD_VAR: state_next = ftmg_pkg::S_DECIDE;
            ftmg_pkg::S_DECIDE:  if (out_free) state_next = ftmg_pkg::S_IDLE;
            default:             state_next = ftmg_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and divider operand loading. The divider is
    // loaded on the edge that enters a division state, with that division's
    // operands.
    always_comb begin
        s_tready     = (state_reg == ftmg_pkg::S_IDLE);
        div_load     = 1'b0;
        div_dq_init  = ftmg_pkg::TIME_DIVIDEND_AL;
        div_divisor  = {1'b0, s_tdata[15:0]};
        div_cnt_init = ftmg_pkg::TIME_CNT;
        if (state_next != state_reg) begin
            case (state_next)
                ftmg_pkg::S_FT: begin
                    div_load = 1'b1;
                end
                ftmg_pkg::S_CPU: begin
                    div_load    = 1'b1;
                    div_divisor = {1'b0, main_rate_reg};
                end
                ftmg_pkg::S_GAIN: begin
                    div_load     = 1'b1;
                    div_dq_init  = {p_reg, 16'd0};
                    div_divisor  = {1'b0, p_reg} + ftmg_pkg::VAR_FLOOR;
                    div_cnt_init = ftmg_pkg::GAIN_CNT;
                end
                ftmg_pkg::S_ENT: begin
                    div_load     = 1'b1;
                    div_dq_init  = ftmg_pkg::THRESH_DIVIDEND_AL;
                    div_divisor  = {9'd0, fps_target_reg};
                    div_cnt_init = ftmg_pkg::THR_CNT;
                end
                ftmg_pkg::S_REL: begin
                    div_load     = 1'b1;
                    div_dq_init  = ftmg_pkg::THRESH_DIVIDEND_AL;
                    div_divisor  = {8'd0, fps_rel_sum};
                    div_cnt_init = ftmg_pkg::THR_CNT;
                end
                default: div_load = 1'b0;
            endcase
        end
    end

    assign fps_rel_sum = {1'b0, fps_target_reg} + {3'd0, fps_margin_reg};

    // One restoring division step. A zero divisor gives all-ones quotient bits,
    // which saturate to the 16-bit maximum as a zero rate requires.
    assign div_shifted  = {rem_reg, dq_reg[31]};
    assign div_diff     = {1'b0, div_shifted} - {2'b00, div_reg};
    assign div_bit      = !div_diff[18];
    assign div_rem_next = div_bit ? div_diff[16:0] : div_shifted[16:0];
    assign div_q_next   = {dq_reg[30:0], div_bit};

    // Shared multiplier operands.
    always_comb begin
        mul_ge = 1'b0;
        mul_a  = {1'b0, k_reg};
        mul_b  = 16'd0;
        case (state_reg)
            ftmg_pkg::S_MUL_FT: begin
                mul_ge = (ft_meas_reg >= frame_est_reg);
                mul_b  = mul_ge ? (ft_meas_reg - frame_est_reg)
                                : (frame_est_reg - ft_meas_reg);
            end
            ftmg_pkg::S_MUL_CPU: begin
                mul_ge = (cpu_meas_reg >= cpu_est_reg);
                mul_b  = mul_ge ? (cpu_meas_reg - cpu_est_reg)
                                : (cpu_est_reg - cpu_meas_reg);
            end
            ftmg_pkg::S_MUL_VAR: begin
                mul_a = 17'h10000 - {1'b0, k_reg};
                mul_b = p_reg;
            end
            default: mul_b = 16'd0;
        endcase
    end

    assign mul_p = {16'd0, mul_a} * {17'd0, mul_b};

    // Estimate update from the registered product.
    assign upd_x    = (state_reg == ftmg_pkg::S_UPD_FT) ? frame_est_reg : cpu_est_reg;
    assign upd_sum  = {1'b0, upd_x} + {1'b0, prod_reg[31:16]};
    assign upd_next = ge_reg ? (upd_sum[16] ? 16'hFFFF : upd_sum[15:0])
                             : (upd_x - prod_reg[31:16]);

    // Variance prediction and seconds counter on accept.
    assign p_sum   = {1'b0, var_reg} + {1'b0, noise_reg};
    assign p_sat   = p_sum[16] ? 16'hFFFF : p_sum[15:0];
    assign sec_inc = (sec_reg == 8'hFF) ? sec_reg : sec_reg + 8'd1;

    // Mode decisions. The reactive logic sees the updated predictive flag.
    assign cpu_rel_thr = (cpu_margin_reg > cpu_thr_reg) ? 16'd0 : cpu_thr_reg - cpu_margin_reg;
    assign deep_eff    = near_reg && deep_reg;
    assign bottleneck  = (frame_est_reg > entry_reg) || (cpu_est_reg > cpu_thr_reg);

    always_comb begin
        pred_next = pred_reg;
        pev_next  = ftmg_pkg::PEV_NONE;
        perf_next = perf_reg;
        mev_next  = ftmg_pkg::MEV_NONE;
        sec_clear = 1'b0;
        if (near_reg) begin
            if (deep_eff && !perf_reg && !pred_reg && (sec_reg > pred_hold_reg)) begin
                pred_next = 1'b1;
                pev_next  = ftmg_pkg::PEV_APPROACH;
            end
        end else if (pred_reg && (sec_reg > pred_rel_reg)) begin
            pred_next = 1'b0;
            pev_next  = ftmg_pkg::PEV_CRUISE;
        end
        if (!perf_reg && !pred_next && bottleneck) begin
            if (sec_reg > switch_hold_reg) begin
                perf_next = 1'b1;
                sec_clear = 1'b1;
                mev_next  = ftmg_pkg::MEV_TO_PERF;
            end
        end else if (perf_reg && !pred_next && (frame_est_reg < release_reg) &&
                     (cpu_est_reg < cpu_rel_thr)) begin
            if (sec_reg > switch_hold_reg) begin
                perf_next = 1'b0;
                sec_clear = 1'b1;
                mev_next  = ftmg_pkg::MEV_TO_QUAL;
            end
        end
    end

    // Register read-back.
    always_comb begin
        prdata = 32'd0;
        unique case (paddr[4:2])
            ftmg_pkg::REG_FPS_TARGET:     prdata = {24'd0, fps_target_reg};
            ftmg_pkg::REG_FPS_MARGIN:     prdata = {26'd0, fps_margin_reg};
            ftmg_pkg::REG_CPU_THRESHOLD:  prdata = {16'd0, cpu_thr_reg};
            ftmg_pkg::REG_CPU_MARGIN:     prdata = {16'd0, cpu_margin_reg};
            ftmg_pkg::REG_SWITCH_HOLDOFF: prdata = {24'd0, switch_hold_reg};
            ftmg_pkg::REG_PRED_HOLDOFF:   prdata = {24'd0, pred_hold_reg};
            ftmg_pkg::REG_PRED_RELEASE:   prdata = {24'd0, pred_rel_reg};
            ftmg_pkg::REG_MEAS_NOISE:     prdata = {16'd0, noise_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ftmg_pkg::S_IDLE;
            fps_target_reg  <= ftmg_pkg::RST_FPS_TARGET;
            fps_margin_reg  <= ftmg_pkg::RST_FPS_MARGIN;
            cpu_thr_reg     <= ftmg_pkg::RST_CPU_THRESHOLD;
            cpu_margin_reg  <= ftmg_pkg::RST_CPU_MARGIN;
            switch_hold_reg <= ftmg_pkg::RST_SWITCH_HOLDOFF;
            pred_hold_reg   <= ftmg_pkg::RST_PRED_HOLDOFF;
            pred_rel_reg    <= ftmg_pkg::RST_PRED_RELEASE;
            noise_reg       <= ftmg_pkg::RST_MEAS_NOISE;
            frame_est_reg   <= ftmg_pkg::RST_ESTIMATE;
            cpu_est_reg     <= ftmg_pkg::RST_ESTIMATE;
            var_reg         <= ftmg_pkg::RST_VARIANCE;
            perf_reg        <= 1'b0;
            pred_reg        <= 1'b0;
            sec_reg         <= 8'd0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_write) begin
                unique case (paddr[4:2])
                    ftmg_pkg::REG_FPS_TARGET:     fps_target_reg  <= pwdata[7:0];
                    ftmg_pkg::REG_FPS_MARGIN:     fps_margin_reg  <= pwdata[5:0];
                    ftmg_pkg::REG_CPU_THRESHOLD:  cpu_thr_reg     <= pwdata[15:0];
                    ftmg_pkg::REG_CPU_MARGIN:     cpu_margin_reg  <= pwdata[15:0];
                    ftmg_pkg::REG_SWITCH_HOLDOFF: switch_hold_reg <= pwdata[7:0];
                    ftmg_pkg::REG_PRED_HOLDOFF:   pred_hold_reg   <= pwdata[7:0];
                    ftmg_pkg::REG_PRED_RELEASE:   pred_rel_reg    <= pwdata[7:0];
                    ftmg_pkg::REG_MEAS_NOISE:     noise_reg       <= pwdata[15:0];
                    default:                      noise_reg       <= noise_reg;
                endcase
            end

            if (accept) begin
                sec_reg <= sec_inc;
            end

            if (state_reg == ftmg_pkg::S_UPD_FT) begin
                frame_est_reg <= upd_next;
            end
            if (state_reg == ftmg_pkg::S_UPD_CPU) begin
                cpu_est_reg <= upd_next;
            end
            if (state_reg == ftmg_pkg::S_UPD_VAR) begin
                var_reg <= prod_reg[31:16];
            end

            if ((state_reg == ftmg_pkg::S_DECIDE) && out_free) begin
                perf_reg     <= perf_next;
                pred_reg     <= pred_next;
                m_tvalid_reg <= 1'b1;
                if (sec_clear) begin
                    sec_reg <= 8'd0;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            main_rate_reg <= s_tdata[31:16];
            near_reg      <= s_tdata[32];
            deep_reg      <= s_tdata[33];
            p_reg         <= p_sat;
        end

        if (div_load) begin
            dq_reg  <= div_dq_init;
            div_reg <= div_divisor;
            rem_reg <= 17'd0;
            cnt_reg <= div_cnt_init;
        end else if (div_active) begin
            dq_reg  <= div_q_next;
            rem_reg <= div_rem_next;
            cnt_reg <= cnt_reg - 6'd1;
        end

        if (div_active && div_last) begin
            case (state_reg)
                ftmg_pkg::S_FT:   ft_meas_reg  <= ftmg_pkg::sat16(div_q_next);
                ftmg_pkg::S_CPU:  cpu_meas_reg <= ftmg_pkg::sat16(div_q_next);
                ftmg_pkg::S_GAIN: k_reg        <= div_q_next[15:0];
                ftmg_pkg::S_ENT:  entry_reg    <= ftmg_pkg::sat16(div_q_next);
                default:          release_reg  <= ftmg_pkg::sat16(div_q_next);
            endcase
        end

        if ((state_reg == ftmg_pkg::S_MUL_FT) || (state_reg == ftmg_pkg::S_MUL_CPU) ||
            (state_reg == ftmg_pkg::S_MUL_VAR)) begin
            prod_reg <= mul_p[31:0];
            ge_reg   <= mul_ge;
        end

        if ((state_reg == ftmg_pkg::S_DECIDE) && out_free) begin
            m_tdata_reg <= {2'b00, pev_next, mev_next, pred_next, perf_next,
                            cpu_est_reg, frame_est_reg};
        end
    end

    // A switch to performance always shows performance mode on the same beat.
    `ASSERT_IMP(a_perf_event, m_tvalid && (m_tdata[35:34] == ftmg_pkg::MEV_TO_PERF), m_tdata[32], "perf event without perf mode")
    // The reactive switch into performance is blocked while predictive mode is set.
    `ASSERT_IMP(a_pred_blocks, m_tvalid && m_tdata[33], m_tdata[35:34] != ftmg_pkg::MEV_TO_PERF, "perf switch during predictive mode")
    // An approach event always shows predictive mode on the same beat.
    `ASSERT_IMP(a_approach, m_tvalid && (m_tdata[37:36] == ftmg_pkg::PEV_APPROACH), m_tdata[33], "approach event without predictive mode")
    // One sample at a time: ready drops right after a beat is taken.
    `ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "ready stayed high after accept")

endmodule

`default_nettype wire
